// File: sv/cabw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the clipped alpha-blend pixel writer.
// No dependencies; every module of the block refers to it by scoped names.

package cabw_pkg;

    // Frame geometry and store size
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(2 * MAX_HEIGHT);

    localparam logic [COL_W:0]   COL_LIMIT = (COL_W + 1)'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(2 * MAX_HEIGHT - 1);

    // Queue between classifier and store engine
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd7;

    localparam logic [7:0] RST_FRAME_WIDTH = 8'd128;
    localparam logic [7:0] RST_CLIP_RIGHT  = 8'd128;
    localparam logic [7:0] RST_CLIP_BOTTOM = 8'd128;

    // Mode register bits
    localparam int MODE_PLANE_ON   = 0;
    localparam int MODE_SRC_ALPHA  = 1;
    localparam int MODE_FOUR_BYTE  = 2;
    localparam int MODE_KEEP_ALPHA = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [15:0] BLEND_ROUND = 16'h0080;

    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,
        KIND_OPAQUE = 2'd1,
        KIND_BLEND  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] offset;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
    } t_job;

    typedef struct packed {
        logic [7:0]        frame_width;
        logic signed [8:0] origin_x;
        logic signed [8:0] origin_y;
        logic [7:0]        clip_left;
        logic [7:0]        clip_top;
        logic [7:0]        clip_right;
        logic [7:0]        clip_bottom;
        logic [3:0]        mode;
    } t_cfg;

endpackage

// File: sv/cabw_front.sv
`timescale 1ns / 1ps
// Front end: raster position, clip test, store offset and item classification.
// Depends on cabw_pkg.

module cabw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cabw_pkg::t_cfg        i_cfg,
    input  logic                  i_clearing,
    input  logic                  i_q_full,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [7:0]            i_pixel_red,
    input  logic [7:0]            i_pixel_green,
    input  logic [7:0]            i_pixel_blue,
    input  logic [7:0]            i_pixel_alpha,
    output logic                  o_push,
    output cabw_pkg::t_job        o_job
);

    logic [cabw_pkg::COL_W-1:0] r_col, n_col;
    logic [cabw_pkg::ROW_W-1:0] r_row, n_row;

    logic              accept;
    logic signed [9:0] fx, fy;
    logic              in_clip;
    logic [15:0]       row_base;
    logic [15:0]       offset_full;
    logic [7:0]        eff_alpha;
    logic              plane_on;
    logic [cabw_pkg::COL_W:0] col_inc;

    assign o_in_stall = i_q_full || i_clearing;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept;

    always_comb begin
        fx = 10'(i_cfg.origin_x) + $signed({3'b000, r_col});
        fy = 10'(i_cfg.origin_y) + $signed({2'b00, r_row});
        in_clip = (fx >= $signed({2'b00, i_cfg.clip_left}))
               && (fx <  $signed({2'b00, i_cfg.clip_right}))
               && (fy >= $signed({2'b00, i_cfg.clip_top}))
               && (fy <  $signed({2'b00, i_cfg.clip_bottom}));
        // within the clip both coordinates are in 0..254
        row_base    = {8'b0, fy[7:0]} * {8'b0, i_cfg.frame_width};
        offset_full = row_base + {8'b0, fx[7:0]};

        plane_on  = i_cfg.mode[cabw_pkg::MODE_PLANE_ON];
        eff_alpha = (plane_on && i_cfg.mode[cabw_pkg::MODE_SRC_ALPHA])
                  ? i_pixel_alpha : cabw_pkg::ALPHA_OPAQUE;

        o_job.offset = offset_full[cabw_pkg::ADDR_W-1:0];
        o_job.red    = i_pixel_red;
        o_job.green  = i_pixel_green;
        o_job.blue   = i_pixel_blue;
        o_job.alpha  = eff_alpha;
        if (i_req_type || !in_clip || (plane_on && eff_alpha == 8'd0)) begin
            o_job.kind = cabw_pkg::KIND_SKIP;
        end else if (eff_alpha == cabw_pkg::ALPHA_OPAQUE) begin
            o_job.kind = cabw_pkg::KIND_OPAQUE;
        end else begin
            o_job.kind = cabw_pkg::KIND_BLEND;
        end
    end

    // raster advance: restart returns to column and row 0, else wrap at frame width or store width, row saturates
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        col_inc = {1'b0, r_col} + 1'b1;
        if (accept) begin
            if (i_req_type) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= i_cfg.frame_width || col_inc >= cabw_pkg::COL_LIMIT) begin
                n_col = '0;
                if (r_row != cabw_pkg::ROW_LIMIT) begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = col_inc[cabw_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: sv/cabw_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the store engine.
// Depends on cabw_pkg for the job type.

module cabw_queue #(
    parameter int DEPTH = cabw_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cabw_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output cabw_pkg::t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cabw_pkg::t_job   r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

endmodule

// File: sv/cabw_back.sv
`timescale 1ns / 1ps
// Store engine: colour store and alpha plane, read-modify-write blend, result register.
// Depends on cabw_pkg.

module cabw_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [3:0]                  i_mode,
    input  logic                        i_q_valid,
    input  cabw_pkg::t_job              i_q_job,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_written,
    output logic [cabw_pkg::ADDR_W-1:0] o_pixel_offset,
    output logic [7:0]                  o_out_red,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_blue,
    output logic [7:0]                  o_out_alpha_byte,
    output logic [7:0]                  o_plane_alpha
);

    localparam int AW = cabw_pkg::ADDR_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MIX   = 4'b0100,
        ST_BLEND = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;

    // colour word holds R,G,B only; no fourth byte is stored
    logic [7:0]  r_alpha_plane  [cabw_pkg::STORE_DEPTH];
    logic [23:0] r_colour_store [cabw_pkg::STORE_DEPTH];

    logic [AW-1:0]  r_clr_addr;
    cabw_pkg::t_job r_cur;
    logic [7:0]     r_rd_alpha;
    logic [23:0]    r_rd_col;
    logic [23:0]    r_old_col;
    logic [7:0]     r_a2;
    logic           r_olda_nz;

    logic          r_out_valid;
    logic          r_written;
    logic [AW-1:0] r_offset;
    logic [7:0]    r_red, r_green, r_blue, r_abyte, r_pa;

    logic          out_free, load_out;
    logic          n_written;
    logic [AW-1:0] n_offset;
    logic [7:0]    n_red, n_green, n_blue, n_abyte, n_pa;

    logic          alpha_we, col_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    alpha_wdata;
    logic [23:0]   col_wdata;

    logic        plane_on, four, keep;
    logic [15:0] a2_prod;
    logic [15:0] p_src_r, p_src_g, p_src_b, p_old_r, p_old_g, p_old_b;
    logic [16:0] s_r, s_g, s_b;
    logic [7:0]  bl_r, bl_g, bl_b, bl_pa, bl_abyte;

    assign plane_on = i_mode[cabw_pkg::MODE_PLANE_ON];
    assign four     = i_mode[cabw_pkg::MODE_FOUR_BYTE];
    assign keep     = i_mode[cabw_pkg::MODE_KEEP_ALPHA];
    assign out_free = !r_out_valid || !i_out_stall;

    // blend datapath: a2 product in the mix state, channel products in the blend state
    always_comb begin
        a2_prod = {8'b0, r_rd_alpha} * {8'b0, cabw_pkg::ALPHA_OPAQUE - r_cur.alpha}
                + cabw_pkg::BLEND_ROUND;
        p_src_r = {8'b0, r_cur.red}   * {8'b0, r_cur.alpha};
        p_src_g = {8'b0, r_cur.green} * {8'b0, r_cur.alpha};
        p_src_b = {8'b0, r_cur.blue}  * {8'b0, r_cur.alpha};
        p_old_r = {8'b0, r_old_col[23:16]} * {8'b0, r_a2};
        p_old_g = {8'b0, r_old_col[15:8]}  * {8'b0, r_a2};
        p_old_b = {8'b0, r_old_col[7:0]}   * {8'b0, r_a2};
        s_r = {1'b0, p_src_r} + {1'b0, p_old_r};
        s_g = {1'b0, p_src_g} + {1'b0, p_old_g};
        s_b = {1'b0, p_src_b} + {1'b0, p_old_b};
        if (r_olda_nz) begin
            bl_r  = s_r[15:8];
            bl_g  = s_g[15:8];
            bl_b  = s_b[15:8];
            bl_pa = r_cur.alpha + r_a2;
        end else begin
            bl_r  = r_cur.red;
            bl_g  = r_cur.green;
            bl_b  = r_cur.blue;
            bl_pa = r_cur.alpha;
        end
        bl_abyte = keep ? bl_pa : cabw_pkg::ALPHA_OPAQUE;
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        load_out    = 1'b0;
        n_written   = 1'b0;
        n_offset    = '0;
        n_red       = '0;
        n_green     = '0;
        n_blue      = '0;
        n_abyte     = '0;
        n_pa        = '0;
        alpha_we    = 1'b0;
        col_we      = 1'b0;
        wr_addr     = r_cur.offset;
        alpha_wdata = '0;
        col_wdata   = {bl_r, bl_g, bl_b};
        case (r_state)
            ST_CLEAR: begin
                alpha_we = 1'b1;
                wr_addr  = r_clr_addr;
                if (r_clr_addr == AW'(cabw_pkg::STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_job.kind)
                        cabw_pkg::KIND_BLEND: begin
                            o_q_pop = 1'b1;
                            n_state = ST_MIX;
                        end
                        cabw_pkg::KIND_OPAQUE: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                load_out    = 1'b1;
                                n_written   = 1'b1;
                                n_offset    = i_q_job.offset;
                                n_red       = i_q_job.red;
                                n_green     = i_q_job.green;
                                n_blue      = i_q_job.blue;
                                n_abyte     = four ? cabw_pkg::ALPHA_OPAQUE : 8'd0;
                                n_pa        = plane_on ? cabw_pkg::ALPHA_OPAQUE : 8'd0;
                                col_we      = 1'b1;
                                alpha_we    = plane_on;
                                wr_addr     = i_q_job.offset;
                                alpha_wdata = cabw_pkg::ALPHA_OPAQUE;
                                col_wdata   = {i_q_job.red, i_q_job.green, i_q_job.blue};
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_q_pop  = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_MIX: begin
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_written   = 1'b1;
                    n_offset    = r_cur.offset;
                    n_red       = bl_r;
                    n_green     = bl_g;
                    n_blue      = bl_b;
                    n_abyte     = four ? bl_abyte : 8'd0;
                    n_pa        = bl_pa;
                    col_we      = 1'b1;
                    alpha_we    = 1'b1;
                    alpha_wdata = bl_pa;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_job;
        end
        if (r_state == ST_MIX) begin
            r_a2      <= a2_prod[15:8];
            r_olda_nz <= (r_rd_alpha != 8'd0);
            r_old_col <= r_rd_col;
        end
        if (load_out) begin
            r_written <= n_written;
            r_offset  <= n_offset;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_abyte   <= n_abyte;
            r_pa      <= n_pa;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_alpha <= r_alpha_plane[i_q_job.offset];
        if (alpha_we) begin
            r_alpha_plane[wr_addr] <= alpha_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col <= r_colour_store[i_q_job.offset];
        if (col_we) begin
            r_colour_store[wr_addr] <= col_wdata;
        end
    end

    assign o_clearing       = (r_state == ST_CLEAR);
    assign o_out_valid      = r_out_valid;
    assign o_written        = r_written;
    assign o_pixel_offset   = r_offset;
    assign o_out_red        = r_red;
    assign o_out_green      = r_green;
    assign o_out_blue       = r_blue;
    assign o_out_alpha_byte = r_abyte;
    assign o_plane_alpha    = r_pa;

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result presented during alpha plane clear");

    a_mix_to_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX) |=> (r_state == ST_BLEND))
        else $error("blend did not follow alpha read");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE))
        else $error("job taken outside idle state");

endmodule

// File: sv/clipped_alpha_blend_pixel_writer_core.sv
`timescale 1ns / 1ps
// Top level of the clipped alpha-blend pixel writer: config registers, front, queue, back.
// Depends on cabw_pkg, cabw_front, cabw_queue and cabw_back.
//
//   channel   direction  handshake                     payload
//   -------   ---------  ----------------------------  --------------------------------------
//   input     in         i_in_valid / o_in_stall       i_req_type, i_pixel_red/green/blue/alpha
//   result    out        o_out_valid / i_out_stall     o_written, o_pixel_offset, o_out_red/
//                                                      green/blue, o_out_alpha_byte,
//                                                      o_plane_alpha
//   config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Flow: the front end takes one transaction per cycle while the job queue has room and
// no clear runs. The store engine owns the single write port of both stores: a skipped
// or opaque pixel ends in idle, a blended pixel passes idle (alpha/colour read), mix (a2
// product) and blend (channel products with write-back) before the next job is taken.
// Reset: synchronous, active low. Afterwards the alpha plane is cleared one entry per
// cycle, all 16384 entries; o_in_stall stays high until that is done, config is taken.
// Stalls: a full result register holds the engine; the queue lets the front run ahead.

module clipped_alpha_blend_pixel_writer_core #(
    parameter int QUEUE_DEPTH = cabw_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [7:0]                      i_pixel_red,
    input  logic [7:0]                      i_pixel_green,
    input  logic [7:0]                      i_pixel_blue,
    input  logic [7:0]                      i_pixel_alpha,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_written,
    output logic [cabw_pkg::ADDR_W-1:0]     o_pixel_offset,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic [7:0]                      o_out_alpha_byte,
    output logic [7:0]                      o_plane_alpha,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cabw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cabw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cabw_pkg::t_cfg r_cfg;
    logic           cfg_we;

    logic           clearing;
    logic           q_full, q_valid, q_push, q_pop;
    cabw_pkg::t_job front_job, head_job;

    // registers are always writable; writes must only happen while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width <= cabw_pkg::RST_FRAME_WIDTH;
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.clip_left   <= '0;
            r_cfg.clip_top    <= '0;
            r_cfg.clip_right  <= cabw_pkg::RST_CLIP_RIGHT;
            r_cfg.clip_bottom <= cabw_pkg::RST_CLIP_BOTTOM;
            r_cfg.mode        <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                cabw_pkg::REG_FRAME_WIDTH: r_cfg.frame_width <= i_cfg_data[7:0];
                cabw_pkg::REG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data;
                cabw_pkg::REG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data;
                cabw_pkg::REG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data[7:0];
                cabw_pkg::REG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data[7:0];
                cabw_pkg::REG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data[7:0];
                cabw_pkg::REG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data[7:0];
                cabw_pkg::REG_MODE:        r_cfg.mode        <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // front end: raster tracking, clip and classification
    cabw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_clearing    (clearing),
        .i_q_full      (q_full),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_pixel_alpha (i_pixel_alpha),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    // decoupling queue, one job per accepted transaction
    cabw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    // store engine: read-modify-write of colour store and alpha plane
    cabw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (r_cfg.mode),
        .i_q_valid        (q_valid),
        .i_q_job          (head_job),
        .o_q_pop          (q_pop),
        .o_clearing       (clearing),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_written        (o_written),
        .o_pixel_offset   (o_pixel_offset),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_out_alpha_byte (o_out_alpha_byte),
        .o_plane_alpha    (o_plane_alpha)
    );

endmodule

// File: dv/clipped_alpha_blend_pixel_writer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for clipped_alpha_blend_pixel_writer_core: a directed table and
// random phases of pixel traffic, checked against an in-bench blend and store predictor.
// Depends on cabw_pkg and the RTL of the block only.

module clipped_alpha_blend_pixel_writer_core_tb;

    localparam int CYCLE_LIMIT = 600000;   // clear pass plus the slowest run, several times over
    localparam int HOLDOFF_CYCLES = 400;   // long receiver stall that backs the block up

    // One result transaction, laid out like the output ports.
    typedef struct packed {
        logic                        written;
        logic [cabw_pkg::ADDR_W-1:0] offset;
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic [7:0]                  alpha_byte;
        logic [7:0]                  plane;
    } t_pixel_result;

    // One input transaction, with an optional hand-written expectation.
    typedef struct packed {
        logic          restart;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [7:0]    alpha;
        logic          has_golden;
        t_pixel_result golden;
    } t_pixel_req;

    // Directed table row: either a register write or a pixel transaction.
    typedef struct packed {
        logic                           is_reg;
        logic [cabw_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [8:0]                     reg_val;
        t_pixel_req                     req;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_req_type;
    logic [7:0]                      i_pixel_red;
    logic [7:0]                      i_pixel_green;
    logic [7:0]                      i_pixel_blue;
    logic [7:0]                      i_pixel_alpha;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_written;
    logic [cabw_pkg::ADDR_W-1:0]     o_pixel_offset;
    logic [7:0]                      o_out_red;
    logic [7:0]                      o_out_green;
    logic [7:0]                      o_out_blue;
    logic [7:0]                      o_out_alpha_byte;
    logic [7:0]                      o_plane_alpha;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [cabw_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [cabw_pkg::CFG_DATA_W-1:0] i_cfg_data;

    clipped_alpha_blend_pixel_writer_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_pixel_red      (i_pixel_red),
        .i_pixel_green    (i_pixel_green),
        .i_pixel_blue     (i_pixel_blue),
        .i_pixel_alpha    (i_pixel_alpha),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_written        (o_written),
        .o_pixel_offset   (o_pixel_offset),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_out_alpha_byte (o_out_alpha_byte),
        .o_plane_alpha    (o_plane_alpha),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: own copy of the registers, stores and raster position
    // ------------------------------------------------------------------
    cabw_pkg::t_cfg model_cfg;
    logic [31:0]    colour_model [cabw_pkg::STORE_DEPTH];
    logic [7:0]     plane_model  [cabw_pkg::STORE_DEPTH];
    int             raster_col;
    int             raster_row;

    t_pixel_result expected_pixels[$];   // oldest first
    t_dir_row      directed_rows[$];
    t_pixel_req    cur_req;              // payload currently on the input port

    int mismatches;
    int pixels_sent;
    int pixels_written;
    int pixels_blended;
    int results_checked;
    int settings_used;
    int burst_left;
    int cycle_count;
    bit hold_req;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Walk the raster: wrap at frame_width or MAX_WIDTH, row saturates at 2*MAX_HEIGHT-1.
    function automatic void advance_raster();
        if (raster_col + 1 >= int'(model_cfg.frame_width) ||
            raster_col + 1 >= cabw_pkg::MAX_WIDTH) begin
            raster_col = 0;
            if (raster_row < 2 * cabw_pkg::MAX_HEIGHT - 1)
                raster_row++;
        end else begin
            raster_col++;
        end
    endfunction

    // Predicts one result and updates the stores the way the block does.
    function automatic t_pixel_result blend_and_store(input t_pixel_req p);
        t_pixel_result res;
        int   fx, fy, off, a, olda, a2, nr, ng, nb, abyte, pa, top;
        bit   plane_on, four, keep, wr;
        logic [31:0] old;
        res = '0;
        if (p.restart) begin
            raster_col = 0;
            raster_row = 0;
            return res;
        end
        fx = $signed(model_cfg.origin_x) + raster_col;
        fy = $signed(model_cfg.origin_y) + raster_row;
        if (fx >= int'(model_cfg.clip_left) && fx < int'(model_cfg.clip_right) &&
            fy >= int'(model_cfg.clip_top) && fy < int'(model_cfg.clip_bottom)) begin
            off      = (fy * int'(model_cfg.frame_width) + fx) % cabw_pkg::STORE_DEPTH;
            plane_on = model_cfg.mode[cabw_pkg::MODE_PLANE_ON];
            four     = model_cfg.mode[cabw_pkg::MODE_FOUR_BYTE];
            keep     = model_cfg.mode[cabw_pkg::MODE_KEEP_ALPHA];
            // source alpha only counts with the plane on; otherwise opaque
            a  = (plane_on && model_cfg.mode[cabw_pkg::MODE_SRC_ALPHA]) ? int'(p.alpha) : 255;
            nr = p.red;
            ng = p.green;
            nb = p.blue;
            abyte = 255;
            pa = 0;
            wr = 1'b1;
            old = colour_model[off];
            if (plane_on) begin
                if (a == 0) begin
                    wr = 1'b0;                   // fully transparent: skip
                end else if (a < 255) begin
                    olda = plane_model[off];
                    if (olda != 0) begin
                        // "over" blend against what is already there
                        a2 = (olda * (255 - a) + 128) >> 8;
                        nb = ((int'(p.blue)  * a + int'(old[7:0])   * a2) >> 8) & 255;
                        ng = ((int'(p.green) * a + int'(old[15:8])  * a2) >> 8) & 255;
                        nr = ((int'(p.red)   * a + int'(old[23:16]) * a2) >> 8) & 255;
                        pa = (a + a2) & 255;
                        pixels_blended++;
                    end else begin
                        pa = a;                  // empty plane entry: direct write
                    end
                    abyte = keep ? pa : 255;
                end else begin
                    pa = a;
                end
                if (wr)
                    plane_model[off] = pa[7:0];
            end
            if (wr) begin
                top = four ? abyte : int'(old[31:24]);   // three-byte keeps the old top byte
                colour_model[off] = {top[7:0], nr[7:0], ng[7:0], nb[7:0]};
                res.written    = 1'b1;
                res.offset     = off[cabw_pkg::ADDR_W-1:0];
                res.red        = nr[7:0];
                res.green      = ng[7:0];
                res.blue       = nb[7:0];
                res.alpha_byte = four ? abyte[7:0] : 8'h00;
                res.plane      = pa[7:0];
                pixels_written++;
            end
        end
        advance_raster();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: results are checked before new expectations are queued,
    // both from values seen just before the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_pixel_result got;
        t_pixel_result want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = {o_written, o_pixel_offset, o_out_red, o_out_green, o_out_blue,
                       o_out_alpha_byte, o_plane_alpha};
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, got %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("written", 16'(want.written), 16'(got.written));
                    check_field("pixel_offset", 16'(want.offset), 16'(got.offset));
                    check_field("out_red", 16'(want.red), 16'(got.red));
                    check_field("out_green", 16'(want.green), 16'(got.green));
                    check_field("out_blue", 16'(want.blue), 16'(got.blue));
                    check_field("out_alpha_byte", 16'(want.alpha_byte),
                                16'(got.alpha_byte));
                    check_field("plane_alpha", 16'(want.plane), 16'(got.plane));
                    results_checked++;
                end
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                // predictor always runs so its state tracks the block
                want = blend_and_store(cur_req);
                if (cur_req.has_golden)
                    want = cur_req.golden;
                expected_pixels.push_back(want);
                pixels_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern is redrawn after each run of random length; on request
    // it holds off for a long stretch so the queue fills and input stalls.
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int pat_mode;
        int pat_left;
        hold_left = 0;
        pat_mode = 0;
        pat_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 200);
                end
                pat_left--;
                case (pat_mode)
                    0: i_out_stall = 1'b0;                           // free flowing
                    1: i_out_stall = ($urandom_range(0, 99) < 30);
                    2: i_out_stall = ($urandom_range(0, 99) < 75);
                    default: i_out_stall = (pat_left % 4 != 0);      // periodic
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached, %0d results still expected", $time,
                 expected_pixels.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all entered and left at a falling edge)
    // ------------------------------------------------------------------

    // Offer one transaction; sender works in bursts with random idle gaps.
    task automatic offer(input t_pixel_req p);
        int gap;
        cur_req       = p;
        i_req_type    = p.restart;
        i_pixel_red   = p.red;
        i_pixel_green = p.green;
        i_pixel_blue  = p.blue;
        i_pixel_alpha = p.alpha;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Drop valid and wait for every expected result to come back.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; unused upper data bits are randomized since the block masks them.
    task automatic write_reg(input logic [cabw_pkg::CFG_IDX_W-1:0] idx, input int val);
        logic [8:0] data;
        data = val[8:0];
        if (idx != cabw_pkg::REG_ORIGIN_X && idx != cabw_pkg::REG_ORIGIN_Y)
            data[8] = $urandom_range(0, 1);
        if (idx == cabw_pkg::REG_MODE)
            data[7:4] = 4'($urandom);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            cabw_pkg::REG_FRAME_WIDTH: model_cfg.frame_width = data[7:0];
            cabw_pkg::REG_ORIGIN_X:    model_cfg.origin_x    = data;
            cabw_pkg::REG_ORIGIN_Y:    model_cfg.origin_y    = data;
            cabw_pkg::REG_CLIP_LEFT:   model_cfg.clip_left   = data[7:0];
            cabw_pkg::REG_CLIP_TOP:    model_cfg.clip_top    = data[7:0];
            cabw_pkg::REG_CLIP_RIGHT:  model_cfg.clip_right  = data[7:0];
            cabw_pkg::REG_CLIP_BOTTOM: model_cfg.clip_bottom = data[7:0];
            cabw_pkg::REG_MODE:        model_cfg.mode        = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input int fw, input int ox, input int oy, input int cl,
                                  input int ct, input int cr, input int cb, input int md);
        wait_idle();
        write_reg(cabw_pkg::REG_FRAME_WIDTH, fw);
        write_reg(cabw_pkg::REG_ORIGIN_X, ox);
        write_reg(cabw_pkg::REG_ORIGIN_Y, oy);
        write_reg(cabw_pkg::REG_CLIP_LEFT, cl);
        write_reg(cabw_pkg::REG_CLIP_TOP, ct);
        write_reg(cabw_pkg::REG_CLIP_RIGHT, cr);
        write_reg(cabw_pkg::REG_CLIP_BOTTOM, cb);
        write_reg(cabw_pkg::REG_MODE, md);
        settings_used++;
    endtask

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Mostly a typical value, sometimes either extreme of the register.
    function automatic int pick(input int lo, input int hi, input int typ_lo, input int typ_hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return rand_between(typ_lo, typ_hi);
        endcase
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel_req rand_req(input bit restart);
        t_pixel_req p;
        p = '0;
        p.restart = restart;
        p.red   = rand_channel();
        p.green = rand_channel();
        p.blue  = rand_channel();
        case ($urandom_range(0, 19))
            0, 1:    p.alpha = 8'h00;
            2, 3:    p.alpha = 8'hFF;
            4:       p.alpha = 8'h01;
            5:       p.alpha = 8'hFE;
            default: p.alpha = 8'($urandom);
        endcase
        return p;
    endfunction

    // Random setting, then restart-led raster runs of random length so that
    // small frames get revisited and blended over and over.
    task automatic random_phase(input int n_items, input bit with_holdoff);
        int fw, ox, oy, cl, ct, cr, cb, md, run, sent;
        fw = pick(1, cabw_pkg::MAX_WIDTH, 1,
                  ($urandom_range(0, 1) == 1) ? 12 : cabw_pkg::MAX_WIDTH);
        ox = pick(-255, 255, -3, 6);
        oy = pick(-255, 255, -2, 4);
        cl = pick(0, 128, 0, 6);
        ct = pick(0, 128, 0, 3);
        cr = pick(0, 128, (cl < 128) ? cl + 1 : 128, 128);
        cb = pick(0, 128, (ct < 128) ? ct + 1 : 128, 128);
        case ($urandom_range(0, 7))
            0: md = 4'b1011;
            1: md = 4'b1111;
            2: md = 4'b0011;
            3: md = 4'b0111;
            default: md = $urandom_range(0, 15);
        endcase
        write_all_regs(fw, ox, oy, cl, ct, cr, cb, md);
        if (with_holdoff)
            hold_req = 1'b1;
        sent = 0;
        while (sent < n_items) begin
            offer(rand_req(1'b1));
            sent++;
            run = $urandom_range(1, 3 * fw + 2);
            for (int i = 0; i < run && sent < n_items; i++) begin
                offer(rand_req(1'b0));
                sent++;
            end
        end
    endtask

    // Directed table builders.
    function automatic void add_px(input bit restart, input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] a);
        t_dir_row row;
        row = '0;
        row.req.restart = restart;
        row.req.red   = r;
        row.req.green = g;
        row.req.blue  = b;
        row.req.alpha = a;
        directed_rows.push_back(row);
    endfunction

    // Attach a hand-written expectation to the last row.
    function automatic void add_gold(input bit w, input int off, input logic [7:0] r,
                                     input logic [7:0] g, input logic [7:0] b,
                                     input logic [7:0] ab, input logic [7:0] pa);
        t_dir_row row;
        row = directed_rows.pop_back();
        row.req.has_golden = 1'b1;
        row.req.golden = {w, off[cabw_pkg::ADDR_W-1:0], r, g, b, ab, pa};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [cabw_pkg::CFG_IDX_W-1:0] idx, input int val);
        t_dir_row row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val[8:0];
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        t_pixel_req sat_req;

        // every input known from time zero, reset asserted at the start
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = 1'b0;
        i_pixel_red   = 8'h00;
        i_pixel_green = 8'h00;
        i_pixel_blue  = 8'h00;
        i_pixel_alpha = 8'h00;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = cabw_pkg::REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        cur_req       = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        mismatches    = 0;
        pixels_sent   = 0;
        pixels_written  = 0;
        pixels_blended  = 0;
        results_checked = 0;
        settings_used   = 1;

        model_cfg             = '0;
        model_cfg.frame_width = cabw_pkg::RST_FRAME_WIDTH;
        model_cfg.clip_right  = cabw_pkg::RST_CLIP_RIGHT;
        model_cfg.clip_bottom = cabw_pkg::RST_CLIP_BOTTOM;
        raster_col = 0;
        raster_row = 0;
        for (int k = 0; k < cabw_pkg::STORE_DEPTH; k++) begin
            colour_model[k] = '0;
            plane_model[k]  = '0;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed table ---
        // reset setting: plane off, three-byte, opaque raster writes from offset 0
        add_px(0, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(1, 0, 8'h00, 8'h00, 8'h00, 0, 0);
        add_px(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF); add_gold(1, 1, 8'hFF, 8'hFF, 8'hFF, 0, 0);
        add_px(0, 8'hA5, 8'h5A, 8'h3C, 8'h00); add_gold(1, 2, 8'hA5, 8'h5A, 8'h3C, 0, 0);
        add_px(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'h12, 8'h34, 8'h56, 8'h78); add_gold(1, 0, 8'h12, 8'h34, 8'h56, 0, 0);
        // plane on, source alpha, four-byte, keep alpha
        add_reg(cabw_pkg::REG_MODE, 4'b1111);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        // transparent source: skipped, position still moves on
        add_px(0, 8'h10, 8'h20, 8'h30, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        // empty plane entry: direct write with the source alpha
        add_px(0, 8'h40, 8'h50, 8'h60, 8'h80); add_gold(1, 1, 8'h40, 8'h50, 8'h60, 8'h80, 8'h80);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'hFF, 8'h00, 8'h80, 8'hFF); add_gold(1, 0, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        // true blends over opaque and half-covered pixels
        add_px(0, 8'h00, 8'hFF, 8'h40, 8'h40);
        add_px(0, 8'h9C, 8'h21, 8'hE7, 8'h7F);
        add_px(0, 8'hC3, 8'h3C, 8'h99, 8'h01); add_gold(1, 2, 8'hC3, 8'h3C, 8'h99, 8'h01, 8'h01);
        add_px(0, 8'h7E, 8'hE7, 8'h18, 8'hFE); add_gold(1, 3, 8'h7E, 8'hE7, 8'h18, 8'hFE, 8'hFE);
        // three-byte format: fourth byte reads back as zero
        add_reg(cabw_pkg::REG_MODE, 4'b0011);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'h81, 8'h42, 8'h24, 8'h80);
        add_px(0, 8'h5A, 8'hA5, 8'hF0, 8'hFF); add_gold(1, 1, 8'h5A, 8'hA5, 8'hF0, 0, 8'hFF);
        // plane on but source alpha ignored: opaque even with alpha 0
        add_reg(cabw_pkg::REG_MODE, 4'b0101);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'h11, 8'h22, 8'h33, 8'h00); add_gold(1, 0, 8'h11, 8'h22, 8'h33, 8'hFF, 8'hFF);
        // one-pixel-wide clip window shifted by the origin
        add_reg(cabw_pkg::REG_ORIGIN_X, 1);
        add_reg(cabw_pkg::REG_CLIP_LEFT, 2);
        add_reg(cabw_pkg::REG_CLIP_RIGHT, 3);
        add_reg(cabw_pkg::REG_CLIP_BOTTOM, 1);
        add_px(1, 8'h00, 8'h00, 8'h00, 8'h00); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'hEE, 8'hDD, 8'hCC, 8'hBB); add_gold(0, 0, 0, 0, 0, 0, 0);
        add_px(0, 8'h01, 8'h02, 8'h04, 8'h08); add_gold(1, 2, 8'h01, 8'h02, 8'h04, 8'hFF, 8'hFF);
        add_px(0, 8'h10, 8'h20, 8'h40, 8'h80); add_gold(0, 0, 0, 0, 0, 0, 0);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_reg) begin
                wait_idle();
                write_reg(directed_rows[k].reg_idx, int'(directed_rows[k].reg_val));
            end else begin
                offer(directed_rows[k].req);
            end
        end

        // --- row counter saturation: one-pixel rows, origin pulls the last row into view ---
        write_all_regs(1, 0, -255, 0, 0, 128, 128, $urandom_range(0, 15));
        sat_req = rand_req(1'b1);
        offer(sat_req);
        repeat (300) offer(rand_req(1'b0));

        // --- random phases, one of them with a long receiver hold-off ---
        for (int ph = 0; ph < 10; ph++)
            random_phase(105, ph == 2);

        wait_idle();
        repeat (40) @(negedge i_clk);   // catch any stray result

        $display("Run covered %0d pixel transactions over %0d register settings,", pixels_sent,
                 settings_used);
        $display("%0d stored, %0d blended over old pixels, %0d results checked.",
                 pixels_written, pixels_blended, results_checked);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
